@@ rtl/core/mali_pkg.sv @@
// Shared types, register map and constants of the multi-axis servo move planner.
package mali_pkg;

    localparam int POS_W = 16;
    localparam int STEP_W = 16;
    localparam int PERIOD_W = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [1:0] REG_PULSE_MIN = 2'd0;
    localparam logic [1:0] REG_PULSE_MAX = 2'd1;
    localparam logic [1:0] REG_TICK_PERIOD = 2'd2;
    localparam logic [1:0] REG_DEFAULT_DUR = 2'd3;

    localparam logic [POS_W-1:0] PULSE_MIN_RST = 16'd500;
    localparam logic [POS_W-1:0] PULSE_MAX_RST = 16'd2500;
    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 8'd20;
    localparam logic [STEP_W-1:0] DEFAULT_DUR_RST = 16'd500;

    typedef struct packed {
        logic mode;
        logic [POS_W-1:0] target_a;
        logic [POS_W-1:0] target_b;
        logic [POS_W-1:0] target_c;
        logic [POS_W-1:0] target_d;
        logic [STEP_W-1:0] move_duration_ms;
    } req_item_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [POS_W-1:0] pos_c;
        logic [POS_W-1:0] pos_d;
        logic moving;
        logic done_res;
    } res_item_t;

    typedef struct packed {
        logic [POS_W-1:0] pulse_min;
        logic [POS_W-1:0] pulse_max;
        logic [PERIOD_W-1:0] tick_period_ms;
        logic [STEP_W-1:0] dflt_dur_ms;
    } cfg_t;

    // Home position of each axis after reset.
    function automatic logic [POS_W-1:0] home_pos(input int unsigned idx);
        logic [POS_W-1:0] val;
        case (idx)
            0: val = 16'd2150;
            1: val = 16'd1500;
            2: val = 16'd500;
            default: val = 16'd1500;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/multi_axis_linear_interpolator_top.sv @@
// Ignored requests, starts with no motion and moves that end on a tick go straight from
// acceptance to the output state. A tick inside a move first steps every axis in turn.
// A start that moves runs one step-count division and one increment division per axis
// on the shared bit-serial divider before its result is offered.
// One request is handled at a time; the input stalls until its result is loaded.
// Reset puts the axes at their home positions, with no move in progress and no result held.
module multi_axis_linear_interpolator_top
    import mali_pkg::*;
#(
    parameter int AXES = 4,
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_item_t          req_item,
    output logic               res_valid,
    input  logic               res_stall,
    output res_item_t          res_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int DW = POS_W + FRAC_BITS;
    localparam int ACC_W = DW + 1;
    localparam logic [AXW-1:0] LAST_AXIS = AXW'(AXES - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV_STEPS = 3'd1;
    localparam logic [2:0] ST_DIV_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV_AXIS = 3'd3;
    localparam logic [2:0] ST_TICK = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    cfg_t cfg;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [AXW-1:0]          axis_reg;
    logic [AXW-1:0]          axis_next;
    logic [STEP_W-1:0]       step_total_reg;
    logic [STEP_W-1:0]       step_total_next;
    logic [STEP_W-1:0]       step_count_reg;
    logic [STEP_W-1:0]       step_count_next;
    logic                    moving_reg;
    logic                    moving_next;
    logic                    done_reg;
    logic                    done_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    res_item_t               res_item_reg;
    res_item_t               res_item_next;

    logic [POS_W-1:0]        pos_reg [AXES];
    logic [POS_W-1:0]        goal_reg [AXES];
    logic signed [ACC_W-1:0] acc_reg [AXES];
    logic signed [ACC_W-1:0] inc_reg [AXES];

    logic [POS_W-1:0]        tgt_in [4];
    logic [POS_W-1:0]        tgt [AXES];
    logic [POS_W-1:0]        pos_view [4];
    logic                    any_move;
    logic                    req_acc;
    logic                    start_ok;
    logic                    move_go;
    logic                    tick_ok;
    logic                    tick_end;
    logic                    res_load;
    logic [STEP_W-1:0]       cnt_inc;
    logic [STEP_W-1:0]       dur_sel;
    logic [PERIOD_W-1:0]     period_sel;
    logic [STEP_W-1:0]       steps_q;
    logic [STEP_W-1:0]       steps_sel;
    logic [POS_W-1:0]        goal_cur;
    logic [POS_W-1:0]        pos_cur;
    logic                    neg_dir;
    logic [POS_W-1:0]        mag;
    logic signed [ACC_W-1:0] quo_ext;
    logic signed [ACC_W-1:0] inc_new;
    logic signed [ACC_W-1:0] acc_sum;
    logic [POS_W-1:0]        pos_from_acc;

    logic                    div_start;
    logic [DW-1:0]           div_dividend;
    logic [STEP_W-1:0]       div_divisor;
    logic                    div_done;
    logic [DW-1:0]           div_quo;

    mali_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mali_divider #(
        .DW  (DW),
        .DVW (STEP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc = req_valid && !req_stall;
    assign res_valid = res_valid_reg;
    assign res_item = res_item_reg;

    // Clamp each requested target; axes without an input field keep their position.
    always_comb
    begin
        tgt_in[0] = req_item.target_a;
        tgt_in[1] = req_item.target_b;
        tgt_in[2] = req_item.target_c;
        tgt_in[3] = req_item.target_d;
        any_move = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            if (i < 4)
            begin
                tgt[i] = tgt_in[2'(i)];
                if (tgt[i] < cfg.pulse_min)
                begin
                    tgt[i] = cfg.pulse_min;
                end
                if (tgt[i] > cfg.pulse_max)
                begin
                    tgt[i] = cfg.pulse_max;
                end
            end
            else
            begin
                tgt[i] = pos_reg[i];
            end
            if (tgt[i] != pos_reg[i])
            begin
                any_move = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pos_view[j] = '0;
        end
        for (int i = 0; i < AXES; i++)
        begin
            if (i < 4)
            begin
                pos_view[2'(i)] = pos_reg[i];
            end
        end
    end

    assign start_ok = req_acc && (req_item.mode == MODE_START) && !moving_reg;
    assign move_go = start_ok && any_move;
    assign tick_ok = req_acc && (req_item.mode == MODE_TICK) && moving_reg;
    assign cnt_inc = step_count_reg + STEP_W'(1);
    assign tick_end = (cnt_inc >= step_total_reg);

    assign dur_sel = (req_item.move_duration_ms == '0) ? cfg.dflt_dur_ms
                                                       : req_item.move_duration_ms;
    assign period_sel = (cfg.tick_period_ms == '0) ? PERIOD_W'(1) : cfg.tick_period_ms;
    assign steps_q = div_quo[STEP_W-1:0];
    assign steps_sel = (steps_q == '0) ? STEP_W'(1) : steps_q;

    assign goal_cur = goal_reg[axis_reg];
    assign pos_cur = pos_reg[axis_reg];
    assign neg_dir = (goal_cur < pos_cur);
    assign mag = neg_dir ? (pos_cur - goal_cur) : (goal_cur - pos_cur);
    assign quo_ext = $signed({1'b0, div_quo});
    assign inc_new = neg_dir ? -quo_ext : quo_ext;

    assign acc_sum = acc_reg[axis_reg] + inc_reg[axis_reg];
    assign pos_from_acc = acc_sum[ACC_W-1] ? '0 : acc_sum[DW-1:FRAC_BITS];

    assign div_start = move_go || (state_reg == ST_DIV_LOAD);
    assign div_dividend = (state_reg == ST_IDLE) ? DW'(dur_sel)
                                                 : {mag, {FRAC_BITS{1'b0}}};
    assign div_divisor = (state_reg == ST_IDLE) ? STEP_W'(period_sel) : step_total_reg;

    assign res_load = (state_reg == ST_OUT) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        state_next = state_reg;
        axis_next = axis_reg;
        step_total_next = step_total_reg;
        step_count_next = step_count_reg;
        moving_next = moving_reg;
        done_next = done_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    done_next = (start_ok && !any_move) || (tick_ok && tick_end);
                    axis_next = '0;
                    if (move_go)
                    begin
                        state_next = ST_DIV_STEPS;
                    end
                    else if (tick_ok)
                    begin
                        step_count_next = cnt_inc;
                        if (tick_end)
                        begin
                            moving_next = 1'b0;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_TICK;
                        end
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV_STEPS:
            begin
                if (div_done)
                begin
                    step_total_next = steps_sel;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                state_next = ST_DIV_AXIS;
            end
            ST_DIV_AXIS:
            begin
                if (div_done)
                begin
                    if (axis_reg == LAST_AXIS)
                    begin
                        step_count_next = '0;
                        moving_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        axis_next = axis_reg + AXW'(1);
                        state_next = ST_DIV_LOAD;
                    end
                end
            end
            ST_TICK:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    axis_next = axis_reg + AXW'(1);
                end
            end
            ST_OUT:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_item_next = res_item_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_item_next.pos_a = pos_view[0];
            res_item_next.pos_b = pos_view[1];
            res_item_next.pos_c = pos_view[2];
            res_item_next.pos_d = pos_view[3];
            res_item_next.moving = moving_reg;
            res_item_next.done_res = done_reg;
        end
    end

    // Per-axis state, written one axis at a time except for the goal load and the snap to the goals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                pos_reg[i] <= home_pos(i);
                goal_reg[i] <= '0;
                acc_reg[i] <= '0;
                inc_reg[i] <= '0;
            end
        end
        else
        begin
            if (move_go)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    goal_reg[i] <= tgt[i];
                end
            end
            if ((state_reg == ST_IDLE) && tick_ok && tick_end)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    pos_reg[i] <= goal_reg[i];
                end
            end
            if ((state_reg == ST_DIV_AXIS) && div_done)
            begin
                inc_reg[axis_reg] <= inc_new;
                acc_reg[axis_reg] <= $signed({1'b0, pos_cur, {FRAC_BITS{1'b0}}});
            end
            if (state_reg == ST_TICK)
            begin
                acc_reg[axis_reg] <= acc_sum;
                pos_reg[axis_reg] <= pos_from_acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg <= '0;
            step_total_reg <= '0;
            step_count_reg <= '0;
            moving_reg <= 1'b0;
            done_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            step_total_reg <= step_total_next;
            step_count_reg <= step_count_next;
            moving_reg <= moving_next;
            done_reg <= done_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

@@ rtl/core/mali_apb_regs.sv @@
// APB configuration registers of the move planner.
module mali_apb_regs
    import mali_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_PULSE_MIN:   cfg_next.pulse_min = pwdata[POS_W-1:0];
                REG_PULSE_MAX:   cfg_next.pulse_max = pwdata[POS_W-1:0];
                REG_TICK_PERIOD: cfg_next.tick_period_ms = pwdata[PERIOD_W-1:0];
                REG_DEFAULT_DUR: cfg_next.dflt_dur_ms = pwdata[STEP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PULSE_MIN:   prdata = PDATA_W'(cfg_reg.pulse_min);
            REG_PULSE_MAX:   prdata = PDATA_W'(cfg_reg.pulse_max);
            REG_TICK_PERIOD: prdata = PDATA_W'(cfg_reg.tick_period_ms);
            REG_DEFAULT_DUR: prdata = PDATA_W'(cfg_reg.dflt_dur_ms);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_min <= PULSE_MIN_RST;
            cfg_reg.pulse_max <= PULSE_MAX_RST;
            cfg_reg.tick_period_ms <= TICK_PERIOD_RST;
            cfg_reg.dflt_dur_ms <= DEFAULT_DUR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/mali_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
module mali_divider
    import mali_pkg::*;
#(
    parameter int DW = 32,
    parameter int DVW = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [DW-1:0]  quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] rem_next;
    logic [DW-1:0]  quo_reg;
    logic [DW-1:0]  quo_next;
    logic [DVW-1:0] dvs_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           busy_reg;
    logic           busy_next;
    logic           done_reg;
    logic           done_next;
    logic [DVW:0]   shifted;
    logic [DVW:0]   diff;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff = shifted - {1'b0, dvs_reg};
    assign done = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // A borrow in the trial subtraction means this quotient bit is zero.
            if (!diff[DVW])
            begin
                rem_next = diff[DVW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

@@ rtl/core/mali_checker.sv @@
// Port-level checks of the move planner and their binding to the top level.
module mali_checker
    import mali_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res_item
);

    // A result that is held back stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result withdrawn while stalled");

    // A held-back result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_item))
        else $error("result payload changed while stalled");

    // A finished move is never reported as still moving.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.done_res |-> !res_item.moving)
        else $error("done reported with move in progress");

    // An accepted request keeps the input stalled in the cycle after acceptance.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("new request taken in the cycle after acceptance");

endmodule

bind multi_axis_linear_interpolator_top mali_checker u_mali_checker (.*);
